/* hw/rtl/heap_sort_engine_core_macros.svh */
// Assertion macros used by the heap sort engine checker.
`ifndef HEAP_SORT_ENGINE_CORE_MACROS_SVH
`define HEAP_SORT_ENGINE_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define HSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heap sort engine check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define HSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap sort engine check failed");

`endif

/* hw/rtl/hse_pkg.sv */
// Shared constants and types of the heap sort engine.
`default_nettype none

package hse_pkg;

    localparam int DEPTH  = 1024;
    localparam int VAL_W  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // child index width: 2*i+2 with i < DEPTH
    localparam int LC_W   = ADDR_W + 2;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_FULL   = 2'd1,
        ST_GIVEN  = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
    } t_ram_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
        logic                    last;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/hse_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/hse_sorter.sv */
// Heapsort sequencer: heap build and extraction by sift-down over the value RAM.
`default_nettype none

module hse_sorter
    import hse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_len,
    input  logic [VAL_W-1:0] i_rd_data,
    output t_ram_req         o_ram_req,
    output logic             o_done
);

    typedef enum logic [7:0] {
        SS_IDLE = 8'b0000_0001,
        SS_NEXT = 8'b0000_0010,
        SS_VGET = 8'b0000_0100,
        SS_XV   = 8'b0000_1000,
        SS_XR   = 8'b0001_0000,
        SS_RL   = 8'b0010_0000,
        SS_RR   = 8'b0100_0000,
        SS_DEC  = 8'b1000_0000
    } t_sstate;

    t_sstate                 r_state, n_state;
    logic                    r_phase_x, n_phase_x;
    logic [CNT_W-1:0]        r_k, n_k;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [CNT_W-1:0]        r_hlen, n_hlen;
    logic [ADDR_W-1:0]       r_at, n_at;
    logic signed [VAL_W-1:0] r_v, n_v;
    logic signed [VAL_W-1:0] r_lv, n_lv;
    logic                    r_rc_ok, n_rc_ok;

    logic [CNT_W-1:0]        k_m1;
    logic [LC_W-1:0]         lc;
    logic [LC_W-1:0]         rc;
    logic [LC_W-1:0]         hlen_w;
    logic signed [VAL_W-1:0] rv;
    logic signed [VAL_W-1:0] best;
    logic                    take_l;
    logic                    take_r;

    assign k_m1   = r_k - CNT_W'(1);
    assign lc     = {1'b0, r_at, 1'b1};
    assign rc     = lc + LC_W'(1);
    assign hlen_w = LC_W'(r_hlen);
    assign rv     = $signed(i_rd_data);
    assign take_l = (r_lv > r_v);
    assign best   = take_l ? r_lv : r_v;
    assign take_r = r_rc_ok && (rv > best);

    always_comb begin
        n_state   = r_state;
        n_phase_x = r_phase_x;
        n_k       = r_k;
        n_n       = r_n;
        n_hlen    = r_hlen;
        n_at      = r_at;
        n_v       = r_v;
        n_lv      = r_lv;
        n_rc_ok   = r_rc_ok;
        o_ram_req = '0;
        o_done    = 1'b0;
        unique case (r_state)
            SS_IDLE: begin
                if (i_start) begin
                    n_n       = i_len;
                    n_k       = i_len >> 1;
                    n_phase_x = 1'b0;
                    n_state   = SS_NEXT;
                end
            end
            SS_NEXT: begin
                if (!r_phase_x) begin
                    if (r_k != '0) begin
                        o_ram_req.rd_en   = 1'b1;
                        o_ram_req.rd_addr = k_m1[ADDR_W-1:0];
                        n_at              = k_m1[ADDR_W-1:0];
                        n_hlen            = r_n;
                        n_k               = k_m1;
                        n_state           = SS_VGET;
                    end else begin
                        n_phase_x = 1'b1;
                        n_k       = r_n;
                    end
                end else if (r_k > CNT_W'(1)) begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = k_m1[ADDR_W-1:0];
                    n_at              = '0;
                    n_hlen            = k_m1;
                    n_k               = k_m1;
                    n_state           = SS_XV;
                end else begin
                    o_done  = 1'b1;
                    n_state = SS_IDLE;
                end
            end
            SS_VGET: begin
                n_v     = $signed(i_rd_data);
                n_state = SS_RL;
            end
            SS_XV: begin
                // last heap entry becomes the sifted value, root is read next
                n_v               = $signed(i_rd_data);
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_addr = '0;
                n_state           = SS_XR;
            end
            SS_XR: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = r_hlen[ADDR_W-1:0];
                o_ram_req.wr_data = i_rd_data;
                n_state           = SS_RL;
            end
            SS_RL: begin
                if (lc < hlen_w) begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = lc[ADDR_W-1:0];
                    n_state           = SS_RR;
                end else begin
                    o_ram_req.wr_en   = 1'b1;
                    o_ram_req.wr_addr = r_at;
                    o_ram_req.wr_data = r_v;
                    n_state           = SS_NEXT;
                end
            end
            SS_RR: begin
                n_lv    = $signed(i_rd_data);
                n_rc_ok = (rc < hlen_w);
                if (rc < hlen_w) begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = rc[ADDR_W-1:0];
                end
                n_state = SS_DEC;
            end
            SS_DEC: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = r_at;
                if (take_r) begin
                    o_ram_req.wr_data = rv;
                    n_at              = rc[ADDR_W-1:0];
                    n_state           = SS_RL;
                end else if (take_l) begin
                    o_ram_req.wr_data = r_lv;
                    n_at              = lc[ADDR_W-1:0];
                    n_state           = SS_RL;
                end else begin
                    o_ram_req.wr_data = r_v;
                    n_state           = SS_NEXT;
                end
            end
            default: begin
                n_state = SS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SS_IDLE;
            r_phase_x <= 1'b0;
            r_k       <= '0;
            r_n       <= '0;
            r_hlen    <= '0;
            r_at      <= '0;
            r_rc_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase_x <= n_phase_x;
            r_k       <= n_k;
            r_n       <= n_n;
            r_hlen    <= n_hlen;
            r_at      <= n_at;
            r_rc_ok   <= n_rc_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v  <= n_v;
        r_lv <= n_lv;
    end

endmodule

`default_nettype wire

/* hw/rtl/heap_sort_engine_core.sv */
// Top level of the heap sort engine: load and read control, value RAM, result queue.
`default_nettype none

// A load answers loaded, or full when the set already holds DEPTH values.
// A read of an already sorted set fetches the next value from the value RAM,
// or answers empty once every value has been given. The first read after
// loading sorts the n loaded values in place first: every sift-down level
// reads the left child, reads the right child, then compares and writes
// back, and the heap build plus extraction descend about n * log2(n) levels;
// the pace of the sort is set by the single read port of the value RAM.
// Results wait in a two-entry queue, so a new item is taken while one
// earlier result is still stalled at the output.
module heap_sort_engine_core
    import hse_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_op,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_sorted_value,
    output logic [1:0]              o_status,
    output logic                    o_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SORT  = 4'b0010,
        S_FETCH = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rpos, n_rpos;
    logic             r_sorted, n_sorted;
    t_result          r_q0, n_q0;
    t_result          r_q1, n_q1;
    logic [1:0]       r_qcnt, n_qcnt;

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] rpos_p1;
    logic             push;
    t_result          push_item;
    logic             sort_start;
    logic             sort_done;
    t_ram_req         host_req;
    t_ram_req         sort_req;
    t_ram_req         ram_req;
    logic [VAL_W-1:0] rd_data;

    assign o_in_stall = !((r_state == S_IDLE) && (r_qcnt != 2'd2));
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = (r_qcnt != 2'd0) && !i_out_stall;
    assign cnt_base   = r_sorted ? '0 : r_count;
    assign rpos_p1    = r_rpos + CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rpos     = r_rpos;
        n_sorted   = r_sorted;
        push       = 1'b0;
        push_item  = '{value: '0, status: ST_LOADED, last: 1'b0};
        sort_start = 1'b0;
        host_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!i_op) begin
                        if (r_sorted) begin
                            n_rpos   = '0;
                            n_sorted = 1'b0;
                        end
                        push = 1'b1;
                        if (cnt_base < CNT_W'(DEPTH)) begin
                            host_req.wr_en   = 1'b1;
                            host_req.wr_addr = cnt_base[ADDR_W-1:0];
                            host_req.wr_data = i_value;
                            n_count          = cnt_base + CNT_W'(1);
                        end else begin
                            n_count          = cnt_base;
                            push_item.status = ST_FULL;
                        end
                    end else if (r_sorted) begin
                        n_state = S_FETCH;
                    end else begin
                        sort_start = 1'b1;
                        n_state    = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (sort_done) begin
                    n_sorted = 1'b1;
                    n_state  = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_rpos < r_count) begin
                    host_req.rd_en   = 1'b1;
                    host_req.rd_addr = r_rpos[ADDR_W-1:0];
                    n_state          = S_READ;
                end else begin
                    push             = 1'b1;
                    push_item.status = ST_EMPTY;
                    n_state          = S_IDLE;
                end
            end
            S_READ: begin
                push             = 1'b1;
                push_item.value  = $signed(rd_data);
                push_item.status = ST_GIVEN;
                push_item.last   = (rpos_p1 == r_count);
                n_rpos           = rpos_p1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // two-entry result queue, r_q0 is the head
    always_comb begin
        n_q0   = r_q0;
        n_q1   = r_q1;
        n_qcnt = r_qcnt;
        priority if (push && out_xfer) begin
            if (r_qcnt == 2'd1) begin
                n_q0 = push_item;
            end else begin
                n_q0 = r_q1;
                n_q1 = push_item;
            end
        end else if (push) begin
            if (r_qcnt == 2'd0) begin
                n_q0 = push_item;
            end else begin
                n_q1 = push_item;
            end
            n_qcnt = r_qcnt + 2'd1;
        end else if (out_xfer) begin
            n_q0   = r_q1;
            n_qcnt = r_qcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rpos   <= '0;
            r_sorted <= 1'b0;
            r_qcnt   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rpos   <= n_rpos;
            r_sorted <= n_sorted;
            r_qcnt   <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign ram_req = (r_state == S_SORT) ? sort_req : host_req;

    hse_sorter u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sort_start),
        .i_len     (r_count),
        .i_rd_data (rd_data),
        .o_ram_req (sort_req),
        .o_done    (sort_done)
    );

    hse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid    = (r_qcnt != 2'd0);
    assign o_sorted_value = r_q0.value;
    assign o_status       = r_q0.status;
    assign o_last         = r_q0.last;

endmodule

`default_nettype wire

/* hw/rtl/heap_sort_engine_core_chk.sv */
// Port-level checker of the heap sort engine and its bind to the top level.
`default_nettype none

`include "heap_sort_engine_core_macros.svh"

module heap_sort_engine_core_chk
    import hse_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    o_in_stall,
    input  logic                    i_op,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [VAL_W-1:0] o_sorted_value,
    input  logic [1:0]              o_status,
    input  logic                    o_last
);

    logic load_xfer;

    assign load_xfer = i_in_valid && !o_in_stall && !i_op;

    `HSE_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_sorted_value) && $stable(o_status) && $stable(o_last))
    `HSE_ASSERT_IMP(a_zero_unless_given, o_out_valid && (o_status != ST_GIVEN), (o_sorted_value == '0) && !o_last)
    `HSE_ASSERT_IMP(a_last_only_given, o_out_valid && o_last, o_status == ST_GIVEN)
    `HSE_ASSERT_NXT(a_load_answers, load_xfer, o_out_valid)

endmodule

bind heap_sort_engine_core heap_sort_engine_core_chk u_chk (.*);

`default_nettype wire
